FILE: rtl/mh2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mh2_pkg;

  localparam logic [31:0] MH_MUL = 32'h5bd1e995;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_LAST_FULL,
    KIND_LAST_TAIL
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic        start;
    logic [31:0] init;
    logic [31:0] word;
    logic [1:0]  tail_n;
  } q_entry_t;

  function automatic logic [31:0] mh_mul(input logic [31:0] a);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, MH_MUL};
    return p[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mh2_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mh2_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [31:0]         cfg_seed,
  input  wire                 in_push,
  output logic                in_full,
  input  wire  [30:0]         in_key_length,
  input  wire  [31:0]         in_word,
  input  wire  [2:0]          in_byte_count,
  input  wire                 in_last,
  input  wire                 q_full,
  output logic                q_push,
  output mh2_pkg::q_entry_t   q_data
);
  import mh2_pkg::*;

  logic [31:0] seed_r;
  logic        awaiting_r;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign q_push    = accept;

  always_comb begin
    q_data.start  = awaiting_r;
    q_data.init   = seed_r ^ {1'b0, in_key_length};
    q_data.word   = in_word;
    q_data.tail_n = in_byte_count[1:0];
    priority if (!in_last) begin
      q_data.kind = KIND_BODY;
    end else if (in_byte_count[2]) begin
      q_data.kind = KIND_LAST_FULL;
    end else begin
      q_data.kind = KIND_LAST_TAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= 32'd0;
      awaiting_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        seed_r <= cfg_seed;
      end
      if (accept) begin
        awaiting_r <= in_last;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mh2_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mh2_fifo #(
  parameter int DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  mh2_pkg::q_entry_t   push_data,
  output logic                full,
  input  wire                 pop,
  output logic                valid,
  output mh2_pkg::q_entry_t   pop_data
);
  import mh2_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mh2_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mh2_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  mh2_pkg::q_entry_t   q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  wire                 out_pop,
  output logic [31:0]         out_hash
);
  import mh2_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HM,
    ST_TAIL,
    ST_FIN,
    ST_OUT
  } state_t;

  state_t      state_r;
  logic [31:0] h_r;
  logic [31:0] k_r;
  logic [31:0] word_r;
  logic [1:0]  n_r;
  logic        last_r;
  logic [31:0] res_r;
  logic        res_valid_r;

  logic [31:0] tail_mask;
  logic [31:0] tail_x;
  logic [31:0] mul_a;
  logic [31:0] mul_p;
  logic        res_free;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_empty = !res_valid_r;
  assign out_hash  = res_r;
  assign res_free  = !res_valid_r || out_pop;

  always_comb begin
    unique case (n_r)
      2'd0: tail_mask = 32'h0000_0000;
      2'd1: tail_mask = 32'h0000_00ff;
      2'd2: tail_mask = 32'h0000_ffff;
      2'd3: tail_mask = 32'h00ff_ffff;
    endcase
  end

  assign tail_x = h_r ^ (word_r & tail_mask);

  // one shared constant multiplier
  always_comb begin
    unique case (state_r)
      ST_K1:   mul_a = word_r;
      ST_K2:   mul_a = k_r ^ (k_r >> 24);
      ST_HM:   mul_a = h_r;
      ST_TAIL: mul_a = tail_x;
      ST_FIN:  mul_a = h_r ^ (h_r >> 13);
      default: mul_a = word_r;
    endcase
  end

  assign mul_p = mh_mul(mul_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h_r         <= 32'd0;
      res_valid_r <= 1'b0;
    end else begin
      if (out_pop && res_valid_r && (state_r != ST_OUT)) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_data.start) begin
              h_r <= q_data.init;
            end
            word_r  <= q_data.word;
            n_r     <= q_data.tail_n;
            last_r  <= (q_data.kind != KIND_BODY);
            state_r <= (q_data.kind == KIND_LAST_TAIL) ? ST_TAIL : ST_K1;
          end
        end
        ST_K1: begin
          k_r     <= mul_p;
          state_r <= ST_K2;
        end
        ST_K2: begin
          k_r     <= mul_p;
          state_r <= ST_HM;
        end
        ST_HM: begin
          h_r <= mul_p ^ k_r;
          if (last_r) begin
            n_r     <= 2'd0;
            state_r <= ST_TAIL;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_TAIL: begin
          h_r     <= (n_r != 2'd0) ? mul_p : tail_x;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          h_r     <= mul_p;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (res_free) begin
            res_r       <= h_r ^ (h_r >> 15);
            res_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != ST_IDLE) && ($past(state_r) == ST_IDLE))
    else $error("queue popped outside idle");

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_pop) |=> (res_valid_r && $stable(res_r)))
    else $error("pending result overwritten or lost");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !res_free) |=> (state_r == ST_OUT))
    else $error("result stage left while output busy");

  a_mix_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K1) |=> (state_r == ST_K2) ##1 (state_r == ST_HM))
    else $error("word mix sequence broken");

endmodule

`default_nettype wire

FILE: rtl/murmurhash2_stream.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming 32-bit MurmurHash2. Push one item per key word (little-endian, first byte in
// bits 7:0); the first item of a key carries the key length, which is xored with the seed.
// The item with last set carries 0 to 3 tail bytes or a full word and yields one hash
// on the result queue. The front registers the seed, tracks key start and classifies items
// into a queue of QUEUE_DEPTH entries; the back runs every multiply through one shared
// constant multiplier, one multiply a cycle outside IDLE and OUT, taking items only in
// IDLE. Body: IDLE, K1, K2, HM; tail: IDLE, TAIL, FIN, OUT; full last: also K1, K2, HM;
// OUT waits until the previous hash is popped. The seed write port is always ready.

module murmurhash2_stream #(
  parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_seed,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [30:0] in_key_length,
  input  wire  [31:0] in_word,
  input  wire  [2:0]  in_byte_count,
  input  wire         in_last,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [31:0] out_hash
);
  import mh2_pkg::*;

  q_entry_t push_data;
  q_entry_t pop_data;
  logic     q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  mh2_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_seed      (cfg_seed),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_key_length (in_key_length),
    .in_word       (in_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  mh2_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  mh2_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_hash  (out_hash)
  );

endmodule

`default_nettype wire

FILE: tb/sv/murmurhash2_stream_checker.sv
`timescale 1ns / 1ps

module murmurhash2_stream_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [31:0] cfg_seed,
  input  wire         in_push,
  input  wire         in_full,
  input  wire  [30:0] in_key_length,
  input  wire  [31:0] in_word,
  input  wire  [2:0]  in_byte_count,
  input  wire         in_last,
  input  wire         out_empty,
  input  wire         out_pop,
  input  wire  [31:0] out_hash,
  output int          fail_count,
  output int          pending
);

  import mh2_pkg::MH_MUL;

  logic [31:0] seed_reg;
  logic [31:0] chain_hash;
  bit          at_key_start;
  logic [31:0] expected_hashes[$];
  int          errs;

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] k;
    k = w * MH_MUL;
    k ^= k >> 24;
    k = k * MH_MUL;
    return (h * MH_MUL) ^ k;
  endfunction

  function automatic logic [31:0] close_key(input logic [31:0] h, input logic [31:0] w,
                                            input logic [2:0] n);
    if (n >= 3'd3) h ^= w & 32'h00ff0000;
    if (n >= 3'd2) h ^= w & 32'h0000ff00;
    if (n >= 3'd1) begin
      h ^= w & 32'h000000ff;
      h = h * MH_MUL;
    end
    h ^= h >> 13;
    h = h * MH_MUL;
    h ^= h >> 15;
    return h;
  endfunction

  always @(posedge clk) begin : monitor
    logic [31:0] h;
    logic [31:0] want;
    if (!rst_n) begin
      seed_reg = '0;
      chain_hash = '0;
      at_key_start = 1'b1;
      expected_hashes.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_hashes.size() == 0) begin
          $error("unexpected item: hash actual %h", out_hash);
          errs++;
        end else begin
          want = expected_hashes.pop_front();
          if (want !== out_hash) begin
            $error("hash mismatch: expected %h, actual %h", want, out_hash);
            errs++;
          end
        end
      end
      if (in_push && !in_full) begin
        h = at_key_start ? (seed_reg ^ {1'b0, in_key_length}) : chain_hash;
        if (!in_last) begin
          chain_hash = mix_word(h, in_word);
          at_key_start = 1'b0;
        end else begin
          // a full word on the last item closes the key with an empty tail
          if (in_byte_count >= 3'd4) h = close_key(mix_word(h, in_word), in_word, 3'd0);
          else h = close_key(h, in_word, in_byte_count);
          chain_hash = h;
          at_key_start = 1'b1;
          expected_hashes.push_back(h);
        end
      end
      if (cfg_valid && cfg_ready) seed_reg = cfg_seed;
    end
    pending <= expected_hashes.size();
    fail_count <= errs;
  end

endmodule

FILE: tb/sv/murmurhash2_stream_tb.sv
`timescale 1ns / 1ps

module murmurhash2_stream_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int SETTLE_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_seed = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [30:0] in_key_length = '0;
  logic [31:0] in_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_hash;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int items_sent = 0;
  bit tx_calm = 1'b0;

  murmurhash2_stream i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_seed      (cfg_seed),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_key_length (in_key_length),
    .in_word       (in_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_hash      (out_hash)
  );

  murmurhash2_stream_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_seed      (cfg_seed),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_key_length (in_key_length),
    .in_word       (in_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_hash      (out_hash),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls with calm stretches
  initial begin : drain_side
    int stall;
    int burst_left;
    bit calm;
    burst_left = 0;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 64);
        calm = ($urandom_range(0, 2) == 0);
      end
      burst_left--;
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h00000000;
      1: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_item(input logic [30:0] len, input logic [31:0] w,
                           input logic [2:0] bc, input logic lst);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_key_length <= len;
    in_word <= w;
    in_byte_count <= bc;
    in_last <= lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_seed <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_seed <= $urandom();
    repeat (3) @(posedge clk);
  endtask

  task automatic send_key(input int len_bytes, input logic [30:0] len_field, input bit broken);
    int body_words;
    logic [2:0] bc;
    body_words = len_bytes / 4;
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < body_words; i++) begin
      bc = (broken && $urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      push_item(i == 0 ? len_field : 31'($urandom()), pick_word(), bc, 1'b0);
    end
    bc = (broken && $urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 7)) : 3'(len_bytes % 4);
    push_item(body_words == 0 ? len_field : 31'($urandom()), pick_word(), bc, 1'b1);
  endtask

  initial begin : stimulus
    logic [31:0] phase_seeds[PHASES];
    int phase_start;
    int len_bytes;
    bit broken;
    logic [30:0] len_field;
    phase_seeds[0] = 32'h00000000;
    phase_seeds[1] = 32'hffffffff;
    phase_seeds[2] = $urandom();
    phase_seeds[3] = 32'h80000000;
    phase_seeds[4] = $urandom();
    phase_seeds[5] = 32'h00000001;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      write_seed(phase_seeds[p]);
      phase_start = items_sent;
      if (p == 0) begin
        tx_calm = 1'b1;
        // empty key and each tail length
        push_item(31'd0, 32'hffffffff, 3'd0, 1'b1);
        push_item(31'd1, 32'hffffffff, 3'd1, 1'b1);
        push_item(31'd2, 32'ha5a5a5a5, 3'd2, 1'b1);
        push_item(31'd3, 32'hffffffff, 3'd3, 1'b1);
        // one body word, tail bytes beyond the count are junk
        push_item(31'd4, 32'hffffffff, 3'd4, 1'b0);
        push_item(31'd0, 32'hffffffff, 3'd0, 1'b1);
        // longest length field, extreme words
        push_item(31'h7fffffff, 32'h00000000, 3'd4, 1'b0);
        push_item(31'h7fffffff, 32'hffffffff, 3'd4, 1'b0);
        push_item(31'h00000000, 32'h00000000, 3'd3, 1'b1);
        // full word on the last item
        push_item(31'd8, 32'h12345678, 3'd4, 1'b1);
        push_item(31'd5, 32'hffffffff, 3'd7, 1'b1);
        // body items with a count other than four
        push_item(31'd6, 32'hdeadbeef, 3'd0, 1'b0);
        push_item(31'd6, 32'hcafef00d, 3'd2, 1'b1);
        push_item(31'd7, 32'h0badf00d, 3'd3, 1'b0);
        push_item(31'h7fffffff, 32'h55aa55aa, 3'd7, 1'b0);
        push_item(31'd1, 32'h000000ff, 3'd1, 1'b1);
        // length field that does not match the bytes sent
        push_item(31'h2aaaaaaa, 32'h87654321, 3'd2, 1'b1);
      end
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        broken = ($urandom_range(0, 6) == 0);
        len_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        if (broken) len_field = $urandom_range(0, 1) ? 31'($urandom()) : 31'h7fffffff;
        else len_field = 31'(len_bytes);
        send_key(len_bytes, len_field, broken);
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
